[design/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, microcode layout and the control program of the JSON string
// escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       string_done;
  } char_word_t;

  localparam int UPC_W = 6;
  typedef logic [UPC_W-1:0] upc_t;

  localparam logic REG_IDX_STYLE = 1'b0;

  localparam logic [6:0] CH_BSL = 7'h5C;
  localparam logic [6:0] CH_U   = 7'h75;
  localparam logic [6:0] CH_D   = 7'h64;
  localparam logic [6:0] CH_C   = 7'h63;
  localparam logic [6:0] CH_X   = 7'h78;
  localparam logic [6:0] CH_NUL = 7'h00;

  typedef enum logic [2:0] {
    CS_LIT, CS_ESC, CS_RAW, CS_N3, CS_N2, CS_N1, CS_N0
  } csel_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_DECODE, ACT_LOAD_LO, ACT_LOAD_PEND, ACT_LOAD_C, ACT_CLEAR, ACT_FINISH
  } act_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_GOTO, BR_IF, BR_RETIF, BR_RET, BR_DISPATCH, BR_WAIT
  } br_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_STYLE0, C_STYLE1, C_MORE, C_RETRY, C_FLUSH
  } cond_t;

  typedef enum logic [2:0] {
    CLS_SHORT, CLS_PLAIN, CLS_BSL, CLS_U16, CLS_SUPP, CLS_REJ, CLS_PEND
  } cls_t;

  typedef struct packed {
    logic       emit;
    csel_t      csel;
    logic [6:0] lit;
    act_t       act;
    br_t        br;
    cond_t      cond;
    upc_t       target;
    logic       set_ret;
    upc_t       ret_addr;
  } uword_t;

  typedef struct packed {
    logic style1;
    logic more;
    logic retry;
    logic flush;
    cls_t cls;
  } jse_stat_t;

  localparam upc_t A_IDLE     = 6'd0;
  localparam upc_t A_EVAL     = 6'd1;
  localparam upc_t A_SURR2    = 6'd2;
  localparam upc_t A_REJ      = 6'd3;
  localparam upc_t A_REJ_END  = 6'd4;
  localparam upc_t A_REJ_C    = 6'd5;
  localparam upc_t A_REJ_LD   = 6'd6;
  localparam upc_t A_FIN      = 6'd7;
  localparam upc_t A_END      = 6'd8;
  localparam upc_t A_FIN_LD   = 6'd9;
  localparam upc_t R_SHORT    = 6'd10;
  localparam upc_t R_SHORT_2  = 6'd11;
  localparam upc_t R_PLAIN    = 6'd12;
  localparam upc_t R_BS       = 6'd13;
  localparam upc_t R_BS_2     = 6'd14;
  localparam upc_t R_BS_3     = 6'd15;
  localparam upc_t R_BS_4     = 6'd16;
  localparam upc_t R_U16      = 6'd17;
  localparam upc_t R_U16_2    = 6'd18;
  localparam upc_t R_U16_3    = 6'd19;
  localparam upc_t R_U16_4    = 6'd20;
  localparam upc_t R_U16_5    = 6'd21;
  localparam upc_t R_U16_6    = 6'd22;
  localparam upc_t R_INV      = 6'd23;
  localparam upc_t R_INV_2    = 6'd24;
  localparam upc_t R_INV_3    = 6'd25;
  localparam upc_t R_INV_4    = 6'd26;
  localparam upc_t R_INV_5    = 6'd27;
  localparam upc_t R_INV_6    = 6'd28;
  localparam upc_t R_HEXBS    = 6'd29;
  localparam upc_t R_HEXBS_2  = 6'd30;
  localparam upc_t R_HEXBS_3  = 6'd31;
  localparam upc_t R_HEXBS_4  = 6'd32;
  localparam upc_t R_HEXBS_5  = 6'd33;

  function automatic uword_t u_emit(csel_t csel, logic [6:0] lit, br_t br, cond_t cond,
                                    upc_t target);
    uword_t w;
    w.emit     = 1'b1;
    w.csel     = csel;
    w.lit      = lit;
    w.act      = ACT_NONE;
    w.br       = br;
    w.cond     = cond;
    w.target   = target;
    w.set_ret  = 1'b0;
    w.ret_addr = A_IDLE;
    return w;
  endfunction

  function automatic uword_t u_ctl(act_t act, br_t br, cond_t cond, upc_t target,
                                   logic set_ret, upc_t ret_addr);
    uword_t w;
    w.emit     = 1'b0;
    w.csel     = CS_LIT;
    w.lit      = CH_NUL;
    w.act      = act;
    w.br       = br;
    w.cond     = cond;
    w.target   = target;
    w.set_ret  = set_ret;
    w.ret_addr = ret_addr;
    return w;
  endfunction

  function automatic uword_t ucode_rom(upc_t a);
    uword_t w;
    case (a)
      A_IDLE:    w = u_ctl(ACT_NONE, BR_WAIT, C_ALWAYS, A_IDLE, 1'b0, A_IDLE);
      A_EVAL:    w = u_ctl(ACT_DECODE, BR_DISPATCH, C_ALWAYS, A_IDLE, 1'b0, A_IDLE);
      A_SURR2:   w = u_ctl(ACT_LOAD_LO, BR_GOTO, C_ALWAYS, R_U16, 1'b1, A_FIN);
      A_REJ:     w = u_ctl(ACT_NONE, BR_IF, C_MORE, A_REJ_LD, 1'b0, A_IDLE);
      A_REJ_END: w = u_ctl(ACT_CLEAR, BR_IF, C_RETRY, A_EVAL, 1'b0, A_IDLE);
      A_REJ_C:   w = u_ctl(ACT_LOAD_C, BR_GOTO, C_ALWAYS, R_INV, 1'b1, A_FIN);
      A_REJ_LD:  w = u_ctl(ACT_LOAD_PEND, BR_GOTO, C_ALWAYS, R_INV, 1'b1, A_REJ);
      A_FIN:     w = u_ctl(ACT_NONE, BR_IF, C_FLUSH, A_FIN_LD, 1'b0, A_IDLE);
      A_END:     w = u_ctl(ACT_FINISH, BR_GOTO, C_ALWAYS, A_IDLE, 1'b0, A_IDLE);
      A_FIN_LD:  w = u_ctl(ACT_LOAD_PEND, BR_GOTO, C_ALWAYS, R_HEXBS, 1'b1, A_FIN);
      R_SHORT:   w = u_emit(CS_LIT, CH_BSL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_SHORT_2: w = u_emit(CS_ESC, CH_NUL, BR_RET, C_ALWAYS, A_IDLE);
      R_PLAIN:   w = u_emit(CS_RAW, CH_NUL, BR_RET, C_ALWAYS, A_IDLE);
      R_BS:      w = u_emit(CS_LIT, CH_BSL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_BS_2:    w = u_emit(CS_LIT, CH_BSL, BR_RETIF, C_STYLE0, A_IDLE);
      R_BS_3:    w = u_emit(CS_LIT, CH_BSL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_BS_4:    w = u_emit(CS_LIT, CH_BSL, BR_RET, C_ALWAYS, A_IDLE);
      R_U16:     w = u_emit(CS_LIT, CH_BSL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_U16_2:   w = u_emit(CS_LIT, CH_U, BR_NEXT, C_ALWAYS, A_IDLE);
      R_U16_3:   w = u_emit(CS_N3, CH_NUL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_U16_4:   w = u_emit(CS_N2, CH_NUL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_U16_5:   w = u_emit(CS_N1, CH_NUL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_U16_6:   w = u_emit(CS_N0, CH_NUL, BR_RET, C_ALWAYS, A_IDLE);
      R_INV:     w = u_emit(CS_LIT, CH_BSL, BR_IF, C_STYLE1, R_HEXBS_2);
      R_INV_2:   w = u_emit(CS_LIT, CH_U, BR_NEXT, C_ALWAYS, A_IDLE);
      R_INV_3:   w = u_emit(CS_LIT, CH_D, BR_NEXT, C_ALWAYS, A_IDLE);
      R_INV_4:   w = u_emit(CS_LIT, CH_C, BR_NEXT, C_ALWAYS, A_IDLE);
      R_INV_5:   w = u_emit(CS_N1, CH_NUL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_INV_6:   w = u_emit(CS_N0, CH_NUL, BR_RET, C_ALWAYS, A_IDLE);
      R_HEXBS:   w = u_emit(CS_LIT, CH_BSL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_HEXBS_2: w = u_emit(CS_LIT, CH_BSL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_HEXBS_3: w = u_emit(CS_LIT, CH_X, BR_NEXT, C_ALWAYS, A_IDLE);
      R_HEXBS_4: w = u_emit(CS_N1, CH_NUL, BR_NEXT, C_ALWAYS, A_IDLE);
      R_HEXBS_5: w = u_emit(CS_N0, CH_NUL, BR_RET, C_ALWAYS, A_IDLE);
      default:   w = u_ctl(ACT_NONE, BR_GOTO, C_ALWAYS, A_IDLE, 1'b0, A_IDLE);
    endcase
    return w;
  endfunction

  function automatic upc_t disp_target(cls_t cls);
    upc_t t;
    case (cls)
      CLS_SHORT: t = R_SHORT;
      CLS_PLAIN: t = R_PLAIN;
      CLS_BSL:   t = R_BS;
      CLS_U16:   t = R_U16;
      CLS_SUPP:  t = R_U16;
      CLS_REJ:   t = A_REJ;
      CLS_PEND:  t = A_FIN;
      default:   t = A_FIN;
    endcase
    return t;
  endfunction

  function automatic upc_t disp_ret(cls_t cls);
    upc_t t;
    case (cls)
      CLS_SUPP: t = A_SURR2;
      default:  t = A_FIN;
    endcase
    return t;
  endfunction

endpackage

[design/jse_useq.sv]
// ----------------------------------------------------------------------------
// jse_useq
// Microcode sequencer: step counter, return register and branch logic over
// the control program held in the package.
// ----------------------------------------------------------------------------
module jse_useq import jse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      hold,
  input  jse_stat_t stat,
  output uword_t    ctl,
  output logic      idle
);

  upc_t upc;
  upc_t upc_next;
  upc_t ret;
  upc_t ret_next;
  logic cond_true;
  upc_t upc_inc;

  assign ctl     = ucode_rom(upc);
  assign idle    = (upc == A_IDLE);
  assign upc_inc = upc + upc_t'(1);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS: cond_true = 1'b1;
      C_STYLE0: cond_true = !stat.style1;
      C_STYLE1: cond_true = stat.style1;
      C_MORE:   cond_true = stat.more;
      C_RETRY:  cond_true = stat.retry;
      C_FLUSH:  cond_true = stat.flush;
      default:  cond_true = 1'b1;
    endcase
  end

  always_comb begin
    ret_next = ctl.set_ret ? ctl.ret_addr : ret;
    case (ctl.br)
      BR_NEXT:     upc_next = upc_inc;
      BR_GOTO:     upc_next = ctl.target;
      BR_IF:       upc_next = cond_true ? ctl.target : upc_inc;
      BR_RETIF:    upc_next = cond_true ? ret : upc_inc;
      BR_RET:      upc_next = ret;
      BR_DISPATCH: begin
        upc_next = disp_target(stat.cls);
        ret_next = disp_ret(stat.cls);
      end
      BR_WAIT:     upc_next = start ? A_EVAL : A_IDLE;
      default:     upc_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_IDLE;
      ret <= A_IDLE;
    end else if (!hold) begin
      upc <= upc_next;
      ret <= ret_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_eval: assert property (@(posedge clk) disable iff (rst)
    (upc == A_IDLE && start) |=> upc == A_EVAL)
    else $error("sequencer did not leave idle on a new byte");

  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(upc))
    else $error("sequencer moved while held");

  a_upc_in_rom: assert property (@(posedge clk) disable iff (rst)
    upc <= R_HEXBS_5)
    else $error("sequencer left the control program");
`endif

endmodule

[design/utf8_json_string_escaper.sv]
// ----------------------------------------------------------------------------
// utf8_json_string_escaper
// Escapes a raw byte string into JSON string text with UTF-8 validation,
// one ASCII character per output word.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                    Word
// byte     in   byte_valid / byte_stall      byte_word_t (data_byte, final_byte)
// char     out  char_valid / char_stall      char_word_t (out_char, run_last, ...)
// apb      in   psel, penable, pwrite, pready  escape_style at address 0
//
// A byte takes N + 4 control steps, where N is the number of characters it
// produces: one to take it, one to decode it, one per character, two to close.
// A surrogate pair adds one control step, each held byte that is rejected or
// flushed adds two, and a rejected sequence adds three.
// Reset is synchronous and returns the decoder to the accept state.
// A stalled output holds the sequencer only when it has a new word to hand over.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper import jse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  byte_word_t  byte_word,
  output logic        char_valid,
  input  logic        char_stall,
  output char_word_t  char_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_ACCEPT   = 4'd0,
    ST_REJECT   = 4'd1,
    ST_NEED1    = 4'd2,
    ST_NEED2    = 4'd3,
    ST_NEED3    = 4'd4,
    ST_AFTER_E0 = 4'd5,
    ST_AFTER_ED = 4'd6,
    ST_AFTER_F0 = 4'd7,
    ST_AFTER_F4 = 4'd8
  } dstate_t;

  function automatic dstate_t next_st(dstate_t st, logic [7:0] b);
    logic    cont;
    dstate_t ns;
    cont = (b[7:6] == 2'b10);
    case (st)
      ST_ACCEPT: begin
        if (b < 8'h80) ns = ST_ACCEPT;
        else if (b >= 8'hC2 && b <= 8'hDF) ns = ST_NEED1;
        else if (b == 8'hE0) ns = ST_AFTER_E0;
        else if (b == 8'hED) ns = ST_AFTER_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) ns = ST_NEED2;
        else if (b == 8'hF0) ns = ST_AFTER_F0;
        else if (b >= 8'hF1 && b <= 8'hF3) ns = ST_NEED3;
        else if (b == 8'hF4) ns = ST_AFTER_F4;
        else ns = ST_REJECT;
      end
      ST_NEED1:    ns = cont ? ST_ACCEPT : ST_REJECT;
      ST_NEED2:    ns = cont ? ST_NEED1 : ST_REJECT;
      ST_NEED3:    ns = cont ? ST_NEED2 : ST_REJECT;
      ST_AFTER_E0: ns = (b >= 8'hA0 && b <= 8'hBF) ? ST_NEED1 : ST_REJECT;
      ST_AFTER_ED: ns = (b >= 8'h80 && b <= 8'h9F) ? ST_NEED1 : ST_REJECT;
      ST_AFTER_F0: ns = (b >= 8'h90 && b <= 8'hBF) ? ST_NEED2 : ST_REJECT;
      ST_AFTER_F4: ns = (b >= 8'h80 && b <= 8'h8F) ? ST_NEED2 : ST_REJECT;
      default:     ns = ST_REJECT;
    endcase
    return ns;
  endfunction

  function automatic logic [6:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (7'h30 + {3'b000, n}) : (7'h57 + {3'b000, n});
  endfunction

  function automatic logic [6:0] esc_char(logic [7:0] b);
    logic [6:0] ch;
    case (b)
      8'h08:   ch = 7'h62;
      8'h0C:   ch = 7'h66;
      8'h0A:   ch = 7'h6E;
      8'h0D:   ch = 7'h72;
      8'h09:   ch = 7'h74;
      8'h22:   ch = 7'h22;
      default: ch = 7'h3F;
    endcase
    return ch;
  endfunction

  logic        style;
  dstate_t     dstate;
  logic [20:0] accum;
  logic [7:0]  pend [3];
  logic [1:0]  pcnt;
  logic [1:0]  idx;
  logic [7:0]  cur;
  logic        fin;
  logic [15:0] work;
  logic [6:0]  hold_char;
  logic        hold_valid;

  uword_t      ctl;
  jse_stat_t   stat;
  logic        idle;
  logic        block;
  logic        adv;
  logic        push;
  logic        push_last;
  logic [6:0]  ch;
  dstate_t     ns;
  logic [20:0] acc_next;
  cls_t        cls;
  logic [15:0] supp_hi;
  logic        cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_STYLE);
  assign prdata = (paddr[2] == REG_IDX_STYLE) ? {31'd0, style} : 32'd0;

  // Decoder step on the current byte.
  assign ns = next_st(dstate, cur);

  always_comb begin
    if (dstate == ST_ACCEPT) begin
      if (cur < 8'h80) acc_next = {13'd0, cur};
      else if (cur < 8'hE0) acc_next = {16'd0, cur[4:0]};
      else if (cur < 8'hF0) acc_next = {17'd0, cur[3:0]};
      else acc_next = {18'd0, cur[2:0]};
    end else begin
      acc_next = {accum[14:0], cur[5:0]};
    end
  end

  assign supp_hi = 16'hD7C0 + {5'd0, acc_next[20:10]};

  always_comb begin
    if (ns == ST_ACCEPT) begin
      if (acc_next[20:7] == 14'd0) begin
        if (cur == 8'h08 || cur == 8'h0C || cur == 8'h0A || cur == 8'h0D ||
            cur == 8'h09 || cur == 8'h22) begin
          cls = CLS_SHORT;
        end else if (cur == 8'h5C) begin
          cls = CLS_BSL;
        end else if (cur >= 8'h20 && cur <= 8'h7E) begin
          cls = CLS_PLAIN;
        end else begin
          cls = CLS_U16;
        end
      end else if (acc_next[20:16] == 5'd0) begin
        cls = CLS_U16;
      end else begin
        cls = CLS_SUPP;
      end
    end else if (ns == ST_REJECT) begin
      cls = CLS_REJ;
    end else begin
      cls = CLS_PEND;
    end
  end

  assign stat.style1 = style;
  assign stat.more   = (idx < pcnt);
  assign stat.retry  = (cur <= 8'h7F) || (cur >= 8'hC2 && cur <= 8'hF4);
  assign stat.flush  = fin && (idx < pcnt);
  assign stat.cls    = cls;

  jse_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (byte_valid),
    .hold  (block),
    .stat  (stat),
    .ctl   (ctl),
    .idle  (idle)
  );

  assign byte_stall = !idle;

  // Each character waits in the hold register until the next one shows
  // whether it was the last of the byte.
  assign block     = (ctl.emit || ctl.act == ACT_FINISH) && hold_valid && char_valid &&
                     char_stall;
  assign adv       = !block;
  assign push      = adv && hold_valid && (ctl.emit || ctl.act == ACT_FINISH);
  assign push_last = (ctl.act == ACT_FINISH);

  always_comb begin
    case (ctl.csel)
      CS_LIT:  ch = ctl.lit;
      CS_ESC:  ch = esc_char(cur);
      CS_RAW:  ch = cur[6:0];
      CS_N3:   ch = hex_char(work[15:12]);
      CS_N2:   ch = hex_char(work[11:8]);
      CS_N1:   ch = hex_char(work[7:4]);
      CS_N0:   ch = hex_char(work[3:0]);
      default: ch = ctl.lit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      style      <= 1'b0;
      dstate     <= ST_ACCEPT;
      accum      <= '0;
      pcnt       <= '0;
      idx        <= '0;
      hold_valid <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        style <= pwdata[0];
      end
      if (adv) begin
        case (ctl.act)
          ACT_DECODE: begin
            accum <= acc_next;
            idx   <= '0;
            if (cls == CLS_PEND) begin
              dstate <= ns;
              if (pcnt != 2'd3) begin
                pcnt <= pcnt + 2'd1;
              end
            end else if (cls != CLS_REJ) begin
              dstate <= ST_ACCEPT;
              pcnt   <= '0;
            end
          end
          ACT_LOAD_PEND: idx <= idx + 2'd1;
          ACT_CLEAR: begin
            dstate <= ST_ACCEPT;
            pcnt   <= '0;
            idx    <= '0;
          end
          ACT_FINISH: begin
            if (fin) begin
              dstate <= ST_ACCEPT;
              accum  <= '0;
              pcnt   <= '0;
            end
          end
          default: begin
          end
        endcase
        if (ctl.emit) begin
          hold_valid <= 1'b1;
        end else if (ctl.act == ACT_FINISH) begin
          hold_valid <= 1'b0;
        end
      end
      if (push) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      cur <= byte_word.data_byte;
      fin <= byte_word.final_byte;
    end
    if (adv) begin
      case (ctl.act)
        ACT_DECODE: begin
          if (cls == CLS_PEND && pcnt != 2'd3) begin
            pend[pcnt] <= cur;
          end
          if (cls == CLS_SUPP) begin
            work <= supp_hi;
          end else begin
            work <= acc_next[15:0];
          end
        end
        ACT_LOAD_LO:   work <= {6'b110111, accum[9:0]};
        ACT_LOAD_PEND: work <= {8'd0, pend[idx]};
        ACT_LOAD_C:    work <= {8'd0, cur};
        default: begin
        end
      endcase
      if (ctl.emit) begin
        hold_char <= ch;
      end
    end
    if (push) begin
      char_word.out_char    <= hold_char;
      char_word.run_last    <= push_last;
      char_word.string_done <= push_last && fin;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    (idle && dstate == ST_ACCEPT) |-> pcnt == 2'd0)
    else $error("bytes held while the decoder is in the accept state");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    idle |-> !hold_valid)
    else $error("a character was left behind at the end of a byte");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_word.string_done) |-> char_word.run_last)
    else $error("string end flagged on a word that does not close its byte");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the UTF-8 JSON string escaper. Byte words are driven with
// random gaps and the character output is stalled at random (both off in the final
// steady stream), including one long hold-off that backs the block up into its input.
// A predictor models the decoder and escaping rules and checks every character word in order.
// ----------------------------------------------------------------------------
module tb import jse_pkg::*;;

  localparam logic [2:0] ADDR_STYLE  = {REG_IDX_STYLE, 2'b00};
  localparam logic [2:0] ADDR_NO_REG = 3'd4;
  localparam int         MAX_CHARS   = 24;
  localparam int         DRAIN_WAIT  = 12;
  localparam int         HOLD_LEN    = 400;

  localparam logic [6:0] ESC_QUOTE = 7'h22;
  localparam logic [6:0] ESC_B     = 7'h62;
  localparam logic [6:0] ESC_F     = 7'h66;
  localparam logic [6:0] ESC_N     = 7'h6E;
  localparam logic [6:0] ESC_R     = 7'h72;
  localparam logic [6:0] ESC_T     = 7'h74;

  typedef enum logic [3:0] {
    DEC_ACCEPT, DEC_REJECT, DEC_NEED1, DEC_NEED2, DEC_NEED3,
    DEC_AFTER_E0, DEC_AFTER_ED, DEC_AFTER_F0, DEC_AFTER_F4
  } dec_state_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  byte_word_t  byte_word;
  logic        char_valid;
  logic        char_stall;
  char_word_t  char_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state.
  logic        style_bit = 1'b0;
  dec_state_e  dec_state = DEC_ACCEPT;
  logic [20:0] cp_accum  = '0;
  logic [7:0]  held [3];
  int          held_cnt  = 0;
  char_word_t  step_chars [$];
  char_word_t  exp_chars [$];

  logic [7:0]  str_bytes [$];
  bit          idle_on     = 1'b1;
  bit          byte_up     = 1'b0;
  int          hold_cycles = 0;
  int          errors      = 0;
  int          bytes_sent  = 0;
  int          strings_sent = 0;
  int          chars_seen  = 0;

  utf8_json_string_escaper i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_word (byte_word),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_word (char_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL utf8_json_string_escaper");
    $finish;
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 7'h30 + 7'(n) : 7'h57 + 7'(n);
  endfunction

  function automatic void emit(input logic [6:0] ch);
    char_word_t w;
    w.out_char    = ch;
    w.run_last    = 1'b0;
    w.string_done = 1'b0;
    if (step_chars.size() < MAX_CHARS) step_chars.push_back(w);
  endfunction

  function automatic void emit_u16(input logic [15:0] v);
    emit(CH_BSL);
    emit(CH_U);
    emit(hex_char(v[15:12]));
    emit(hex_char(v[11:8]));
    emit(hex_char(v[7:4]));
    emit(hex_char(v[3:0]));
  endfunction

  function automatic void emit_hex_bs(input logic [7:0] b);
    emit(CH_BSL);
    emit(CH_BSL);
    emit(CH_X);
    emit(hex_char(b[7:4]));
    emit(hex_char(b[3:0]));
  endfunction

  function automatic void emit_invalid(input logic [7:0] b);
    if (style_bit) begin
      emit_hex_bs(b);
    end else begin
      emit(CH_BSL);
      emit(CH_U);
      emit(CH_D);
      emit(CH_C);
      emit(hex_char(b[7:4]));
      emit(hex_char(b[3:0]));
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c);
    dec_state_e nxt;
    logic       retry;
    logic       cont;
    do begin
      retry = 1'b0;
      cont  = (c >= 8'h80 && c <= 8'hBF);
      if (dec_state == DEC_ACCEPT) begin
        if (c < 8'h80) cp_accum = 21'(c);
        else if (c < 8'hE0) cp_accum = 21'(c[4:0]);
        else if (c < 8'hF0) cp_accum = 21'(c[3:0]);
        else cp_accum = 21'(c[2:0]);
      end else begin
        cp_accum = {cp_accum[14:0], c[5:0]};
      end
      case (dec_state)
        DEC_ACCEPT: begin
          if (c < 8'h80) nxt = DEC_ACCEPT;
          else if (c >= 8'hC2 && c <= 8'hDF) nxt = DEC_NEED1;
          else if (c == 8'hE0) nxt = DEC_AFTER_E0;
          else if (c == 8'hED) nxt = DEC_AFTER_ED;
          else if (c >= 8'hE1 && c <= 8'hEF) nxt = DEC_NEED2;
          else if (c == 8'hF0) nxt = DEC_AFTER_F0;
          else if (c >= 8'hF1 && c <= 8'hF3) nxt = DEC_NEED3;
          else if (c == 8'hF4) nxt = DEC_AFTER_F4;
          else nxt = DEC_REJECT;
        end
        DEC_NEED1:    nxt = cont ? DEC_ACCEPT : DEC_REJECT;
        DEC_NEED2:    nxt = cont ? DEC_NEED1 : DEC_REJECT;
        DEC_NEED3:    nxt = cont ? DEC_NEED2 : DEC_REJECT;
        DEC_AFTER_E0: nxt = (c >= 8'hA0 && c <= 8'hBF) ? DEC_NEED1 : DEC_REJECT;
        DEC_AFTER_ED: nxt = (c >= 8'h80 && c <= 8'h9F) ? DEC_NEED1 : DEC_REJECT;
        DEC_AFTER_F0: nxt = (c >= 8'h90 && c <= 8'hBF) ? DEC_NEED2 : DEC_REJECT;
        DEC_AFTER_F4: nxt = (c >= 8'h80 && c <= 8'h8F) ? DEC_NEED2 : DEC_REJECT;
        default:      nxt = DEC_REJECT;
      endcase
      if (nxt == DEC_ACCEPT) begin
        dec_state = DEC_ACCEPT;
        held_cnt  = 0;
        if (cp_accum <= 21'h7F) begin
          case (c)
            8'h08: begin emit(CH_BSL); emit(ESC_B); end
            8'h0C: begin emit(CH_BSL); emit(ESC_F); end
            8'h0A: begin emit(CH_BSL); emit(ESC_N); end
            8'h0D: begin emit(CH_BSL); emit(ESC_R); end
            8'h09: begin emit(CH_BSL); emit(ESC_T); end
            8'h22: begin emit(CH_BSL); emit(ESC_QUOTE); end
            8'h5C: begin
              emit(CH_BSL);
              emit(CH_BSL);
              if (style_bit) begin
                emit(CH_BSL);
                emit(CH_BSL);
              end
            end
            default: begin
              if (c >= 8'h20 && c <= 8'h7E) emit(c[6:0]);
              else emit_u16({8'h00, c});
            end
          endcase
        end else if (cp_accum <= 21'hFFFF) begin
          emit_u16(cp_accum[15:0]);
        end else begin
          emit_u16(16'hD7C0 + 16'(cp_accum >> 10));
          emit_u16(16'hDC00 + {6'b0, cp_accum[9:0]});
        end
      end else if (nxt == DEC_REJECT) begin
        for (int i = 0; i < held_cnt; i++) emit_invalid(held[i]);
        held_cnt  = 0;
        dec_state = DEC_ACCEPT;
        if (c <= 8'h7F || (c >= 8'hC2 && c <= 8'hF4)) retry = 1'b1;
        else emit_invalid(c);
      end else begin
        dec_state = nxt;
        if (held_cnt < 3) begin
          held[held_cnt] = c;
          held_cnt++;
        end
      end
    end while (retry);
  endfunction

  function automatic void predict_chars(input byte_word_t w);
    char_word_t tail;
    step_chars = {};
    decode_byte(w.data_byte);
    if (w.final_byte) begin
      for (int i = 0; i < held_cnt; i++) emit_hex_bs(held[i]);
      held_cnt  = 0;
      dec_state = DEC_ACCEPT;
      cp_accum  = '0;
    end
    if (step_chars.size() > 0) begin
      tail = step_chars.pop_back();
      tail.run_last    = 1'b1;
      tail.string_done = w.final_byte;
      step_chars.push_back(tail);
    end
    foreach (step_chars[i]) exp_chars.push_back(step_chars[i]);
  endfunction

  always @(posedge clk) begin
    char_word_t want;
    char_word_t got;
    if (!rst && char_valid && !char_stall) begin
      got = char_word;
      chars_seen++;
      if (exp_chars.size() == 0) begin
        note_error($sformatf("Unexpected character word: out=%02h last=%0b done=%0b",
                             got.out_char, got.run_last, got.string_done));
      end else begin
        want = exp_chars.pop_front();
        if (got.out_char !== want.out_char || got.run_last !== want.run_last ||
            got.string_done !== want.string_done) begin
          note_error($sformatf({"Character %0d mismatch: expected out=%02h last=%0b ",
                                "done=%0b, got out=%02h last=%0b done=%0b"},
                               chars_seen, want.out_char, want.run_last, want.string_done,
                               got.out_char, got.run_last, got.string_done));
        end
      end
    end
  end

  initial begin : char_stall_drive
    int n;
    char_stall <= 1'b0;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 17);
      end
      if (n > 0) begin
        char_stall <= 1'b1;
        repeat (n) @(posedge clk);
        char_stall <= 1'b0;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_STYLE) style_bit = data[0];
    @(posedge clk);
  endtask

  task automatic reg_read_check(input logic [2:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== style_bit) begin
      note_error($sformatf("Style readback: expected %0b, got %0b", style_bit, prdata[0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_style(input logic s);
    logic [31:0] v;
    v    = $urandom();
    v[0] = s;
    reg_write(ADDR_STYLE, v);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    byte_word_t w;
    w.data_byte  = b;
    w.final_byte = fin;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      if (byte_up) byte_valid <= 1'b0;
      byte_up = 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    byte_word  <= w;
    byte_valid <= 1'b1;
    byte_up     = 1'b1;
    do @(posedge clk); while (byte_stall);
    predict_chars(w);
    bytes_sent++;
  endtask

  task automatic send_str_bytes();
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic wait_drained();
    if (byte_up) byte_valid <= 1'b0;
    byte_up = 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 + 8'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed symbols with random content, plus stray bytes and
  // sequences cut short or broken.
  function automatic void add_symbol();
    int         kind;
    logic [7:0] lead;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: str_bytes.push_back(8'h00);
          1: str_bytes.push_back(8'h08);
          2: str_bytes.push_back(8'h09);
          3: str_bytes.push_back(8'h0A);
          4: str_bytes.push_back(8'h0C);
          5: str_bytes.push_back(8'h0D);
          6: str_bytes.push_back(8'h22);
          7: str_bytes.push_back(8'h5C);
          8: str_bytes.push_back(8'h7F);
          default: str_bytes.push_back(8'h1F);
        endcase
      end else begin
        str_bytes.push_back(8'($urandom_range(0, 127)));
      end
    end else if (kind < 50) begin
      str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
      str_bytes.push_back(rand_cont());
    end else if (kind < 65) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      str_bytes.push_back(lead);
      if (lead == 8'hE0) str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
      else if (lead == 8'hED) str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
      else str_bytes.push_back(rand_cont());
      str_bytes.push_back(rand_cont());
    end else if (kind < 80) begin
      lead = 8'($urandom_range(8'hF0, 8'hF4));
      str_bytes.push_back(lead);
      if (lead == 8'hF0) str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
      else if (lead == 8'hF4) str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
      else str_bytes.push_back(rand_cont());
      str_bytes.push_back(rand_cont());
      str_bytes.push_back(rand_cont());
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      str_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
      repeat ($urandom_range(0, 2)) str_bytes.push_back(rand_cont());
    end
  endfunction

  task automatic send_strings(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      str_bytes = {};
      repeat ($urandom_range(1, 10)) add_symbol();
      send_str_bytes();
    end
  endtask

  task automatic test_register_port();
    reg_write(ADDR_NO_REG, 32'hFFFF_FFFF);
    reg_read_check(ADDR_STYLE);
    reg_write(ADDR_STYLE, 32'hFFFF_FFFF);
    reg_read_check(ADDR_STYLE);
    reg_write(ADDR_STYLE, 32'hA5A5_A5A4);
    reg_read_check(ADDR_STYLE);
  endtask

  task automatic test_directed_escapes();
    set_style(1'b0);
    str_bytes = '{8'h00, 8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h7F,
                  8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                  8'hFF, 8'hF0, 8'h90, 8'h41};
    send_str_bytes();
    wait_drained();
    set_style(1'b1);
    str_bytes = '{8'h5C, 8'hE1, 8'hC3, 8'hC0, 8'hF1, 8'h80};
    send_str_bytes();
    wait_drained();
  endtask

  task automatic test_random_strings();
    for (int phase = 0; phase < 6; phase++) begin
      set_style(phase[0]);
      send_strings(50);
      wait_drained();
    end
  endtask

  task automatic test_output_holdoff();
    set_style(1'($urandom_range(0, 1)));
    hold_cycles = HOLD_LEN;
    send_strings(40);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_style(1'b0);
    send_strings(25);
    wait_drained();
    set_style(1'b1);
    send_strings(25);
    wait_drained();
  endtask

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_word  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_register_port();
    test_directed_escapes();
    test_random_strings();
    test_output_holdoff();
    test_steady_stream();
    $display("Ran %0d strings (%0d bytes) through both escape styles with random gaps,",
             strings_sent, bytes_sent);
    $display("a %0d-cycle output hold-off and a gap-free stream; %0d characters, %0d errors.",
             HOLD_LEN, chars_seen, errors);
    if (errors == 0) begin
      $display("PASS utf8_json_string_escaper");
    end else begin
      $display("FAIL utf8_json_string_escaper");
    end
    $finish;
  end

endmodule

[filelist.f]
design/jse_pkg.sv
design/jse_useq.sv
design/utf8_json_string_escaper.sv
verif/tb.sv
